FILE: rtl/core/psm_pkg.sv
// Shared types, codes and arithmetic helpers for the point-set match core.
// Used by every module in rtl/core; depends on nothing else.
package psm_pkg;

  // Coordinate format and derived widths.
  localparam int CW       = 32;
  localparam int PT_WORDS = 6;
  localparam int FRAC     = 28;
  localparam int TOL_W    = 28;
  localparam int DIFF_W   = CW + 1;
  localparam int SQ_W     = 2 * TOL_W;
  localparam int PROD_W   = 2 * CW;
  localparam int TERM_W   = PROD_W - FRAC;
  localparam int ACC_W    = TERM_W + 2;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [PT_WORDS-1:0] point_t;

  localparam coord_t CMAX = coord_t'({1'b0, {(CW-1){1'b1}}});
  localparam coord_t CMIN = coord_t'({1'b1, {(CW-1){1'b0}}});

  // Input item kinds.
  localparam logic [1:0] KIND_LOAD_REF = 2'd0;
  localparam logic [1:0] KIND_LOAD_FND = 2'd1;
  localparam logic [1:0] KIND_COMPARE  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_TOLERANCE   = 1'b1;

  // Reported match forms.
  localparam logic [2:0] FORM_NONE       = 3'd0;
  localparam logic [2:0] FORM_DIRECT     = 3'd1;
  localparam logic [2:0] FORM_CONJ       = 3'd2;
  localparam logic [2:0] FORM_SHIFT      = 3'd3;
  localparam logic [2:0] FORM_SHIFT_CONJ = 3'd4;

  // Cell operations.
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_LOAD = 2'd1;
  localparam logic [1:0] CELL_CONJ = 2'd2;

  // Row operations.
  localparam logic [2:0] ROW_HOLD  = 3'd0;
  localparam logic [2:0] ROW_ROT   = 3'd1;
  localparam logic [2:0] ROW_PUSH  = 3'd2;
  localparam logic [2:0] ROW_WRITE = 3'd3;
  localparam logic [2:0] ROW_COPY  = 3'd4;
  localparam logic [2:0] ROW_CONJ  = 3'd5;

  // Negation that maps the most negative value to the most positive one.
  function automatic coord_t neg_sat(coord_t v);
    if (v == CMIN) return CMAX;
    return -v;
  endfunction

  // Saturate a wide accumulator to the coordinate width.
  function automatic coord_t sat_acc(logic signed [ACC_W-1:0] x);
    logic [ACC_W-CW:0] top;
    top = x[ACC_W-1:CW-1];
    if (top == '0 || top == '1) return x[CW-1:0];
    return x[ACC_W-1] ? CMIN : CMAX;
  endfunction

  // Magnitude of the difference of two coordinates.
  function automatic logic [DIFF_W-1:0] mag_diff(coord_t a, coord_t b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  // Ordering: a comes after b on the first coordinate, or on the second when the first lie within tolerance.
  function automatic logic comes_after(point_t a, point_t b, logic [TOL_W-1:0] tol);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] m;
    d = DIFF_W'(a[0]) - DIFF_W'(b[0]);
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    if (m > DIFF_W'(tol)) return !d[DIFF_W-1];
    return a[1] > b[1];
  endfunction

endpackage

FILE: rtl/core/point_set_match_under_symmetry_core.sv
// Point-set match core. A compare runs bubble passes (one point leaves the row
// head per cycle), a set check, and per origin an origin fetch plus a shift
// through the shared multiplier. One item at a time; busy is high until the result
// strobe, done, pulses once, and results cannot be stalled. Synchronous reset
// clears control and sets point_count 8 and tolerance 268. Uses psm_pkg, psm_row,
// psm_sorter and psm_shift.
module point_set_match_under_symmetry_core import psm_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind,
  input  logic [2:0]           point_index,
  input  logic signed [31:0]   first_re,
  input  logic signed [31:0]   first_im,
  input  logic signed [31:0]   second_re,
  input  logic signed [31:0]   second_im,
  input  logic signed [31:0]   third_re,
  input  logic signed [31:0]   third_im,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [TOL_W-1:0]     cfg_data,
  output logic                 done,
  output logic                 matched,
  output logic [2:0]           match_form,
  output logic [2:0]           match_origin
);

  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SORT  = 4'd1;
  localparam logic [3:0] ST_SORTF = 4'd2;
  localparam logic [3:0] ST_CPW   = 4'd3;
  localparam logic [3:0] ST_EQI   = 4'd4;
  localparam logic [3:0] ST_EQ    = 4'd5;
  localparam logic [3:0] ST_EQD   = 4'd6;
  localparam logic [3:0] ST_CONJ  = 4'd7;
  localparam logic [3:0] ST_PRE   = 4'd8;
  localparam logic [3:0] ST_GEN   = 4'd9;

  localparam logic [1:0] SEL_R = 2'd0;
  localparam logic [1:0] SEL_F = 2'd1;
  localparam logic [1:0] SEL_W = 2'd2;

  logic [3:0]       state, ret;
  logic [1:0]       sel;
  logic [3:0]       point_count;
  logic [TOL_W-1:0] tolerance;
  logic [NW-1:0]    n_eff, n_reg, k, pcnt, i, o;
  logic [1:0]       j;
  logic             swapped, fail, gen_wait;
  logic [2:0]       try_form;
  logic [SQ_W-1:0]  tol_sq;
  point_t           orig, load_pt, sort_front, emit, u_res, w_ins;
  logic             swap, sort_en, sort_first, sort_last, load_ok;
  logic             u_start, u_done;
  logic [2:0]       op_ref, op_fnd, op_r, op_f, op_w, op_sort;
  logic [IW-1:0]    wr_idx;
  point_t           ref_cells [MAX_POINTS];
  point_t           fnd_cells [MAX_POINTS];
  point_t           r_cells [MAX_POINTS];
  point_t           f_cells [MAX_POINTS];
  point_t           w_cells [MAX_POINTS];

  // Set-check pipeline registers.
  logic             v1, v2, bad1, bad2;
  logic [TOL_W-1:0] mr1, mi1;
  logic [SQ_W-1:0]  sqr, sqi;
  logic [DIFF_W-1:0] mr, mi;

  assign busy = (state != ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 4'd8;
      tolerance   <= TOL_W'(268);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_POINT_COUNT: point_count <= cfg_data[3:0];
        CFG_TOLERANCE:   tolerance   <= cfg_data;
        default:         tolerance   <= tolerance;
      endcase
    end
  end

  always_comb begin
    n_eff = (32'(point_count) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(point_count);
    load_ok = (32'(point_index) < MAX_POINTS);
    wr_idx  = IW'(point_index);
    load_pt[0] = coord_t'(first_re);
    load_pt[1] = coord_t'(first_im);
    load_pt[2] = coord_t'(second_re);
    load_pt[3] = coord_t'(second_im);
    load_pt[4] = coord_t'(third_re);
    load_pt[5] = coord_t'(third_im);
  end

  // Sort engine hookup on the selected row.
  always_comb begin
    sort_en    = (state == ST_SORT);
    sort_first = (k == '0);
    sort_last  = (k == n_reg);
    op_sort    = sort_first ? ROW_ROT : ROW_PUSH;
    case (sel)
      SEL_R:   sort_front = r_cells[0];
      SEL_F:   sort_front = f_cells[0];
      default: sort_front = w_cells[0];
    endcase
  end

  psm_sorter u_sorter (
    .clk   (clk),
    .en    (sort_en),
    .first (sort_first),
    .last  (sort_last),
    .front (sort_front),
    .tol   (tolerance),
    .emit  (emit),
    .swap  (swap)
  );

  assign u_start = (state == ST_GEN) && !gen_wait;

  psm_shift u_shift (
    .clk   (clk),
    .rst   (rst),
    .start (u_start),
    .p     (r_cells[0]),
    .org   (orig),
    .self  (i == o),
    .res   (u_res),
    .done  (u_done)
  );

  // Row operations for each state.
  always_comb begin
    op_ref = ROW_HOLD;
    op_fnd = ROW_HOLD;
    op_r   = ROW_HOLD;
    op_f   = ROW_HOLD;
    op_w   = ROW_HOLD;
    w_ins  = (state == ST_GEN) ? u_res : emit;
    case (state)
      ST_IDLE: begin
        if (start && load_ok && kind == KIND_LOAD_REF) op_ref = ROW_WRITE;
        if (start && load_ok && kind == KIND_LOAD_FND) op_fnd = ROW_WRITE;
        if (start && kind == KIND_COMPARE && n_eff != '0) begin
          op_r = ROW_COPY;
          op_f = ROW_COPY;
        end
      end
      ST_SORT: begin
        case (sel)
          SEL_R:   op_r = op_sort;
          SEL_F:   op_f = op_sort;
          default: op_w = op_sort;
        endcase
      end
      ST_CPW:  op_w = ROW_COPY;
      ST_EQ: begin
        if (j == 2'd2) begin
          op_f = ROW_ROT;
          op_w = ROW_ROT;
        end
      end
      ST_CONJ: op_w = ROW_CONJ;
      ST_PRE:  op_r = ROW_ROT;
      ST_GEN: begin
        if (u_done) begin
          op_w = ROW_PUSH;
          op_r = ROW_ROT;
        end
      end
      default: op_w = ROW_HOLD;
    endcase
  end

  psm_row #(.MAX_POINTS(MAX_POINTS)) u_ref (
    .clk(clk), .op(op_ref), .n(n_reg), .wr_idx(wr_idx), .ins(load_pt),
    .cpy(ref_cells), .cells(ref_cells)
  );

  psm_row #(.MAX_POINTS(MAX_POINTS)) u_fnd (
    .clk(clk), .op(op_fnd), .n(n_reg), .wr_idx(wr_idx), .ins(load_pt),
    .cpy(fnd_cells), .cells(fnd_cells)
  );

  psm_row #(.MAX_POINTS(MAX_POINTS)) u_r (
    .clk(clk), .op(op_r), .n(n_reg), .wr_idx(wr_idx), .ins(emit),
    .cpy(ref_cells), .cells(r_cells)
  );

  psm_row #(.MAX_POINTS(MAX_POINTS)) u_f (
    .clk(clk), .op(op_f), .n(n_reg), .wr_idx(wr_idx), .ins(emit),
    .cpy(fnd_cells), .cells(f_cells)
  );

  psm_row #(.MAX_POINTS(MAX_POINTS)) u_w (
    .clk(clk), .op(op_w), .n(n_reg), .wr_idx(wr_idx), .ins(w_ins),
    .cpy(r_cells), .cells(w_cells)
  );

  // Set check: magnitudes, then squares, then the sticky failure flag.
  always_comb begin
    mr = mag_diff(f_cells[0][{j, 1'b0}], w_cells[0][{j, 1'b0}]);
    mi = mag_diff(f_cells[0][{j, 1'b1}], w_cells[0][{j, 1'b1}]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_EQ);
      v2 <= v1;
    end
    bad1 <= (mr > DIFF_W'(tolerance)) || (mi > DIFF_W'(tolerance));
    mr1  <= mr[TOL_W-1:0];
    mi1  <= mi[TOL_W-1:0];
    bad2 <= bad1;
    sqr  <= SQ_W'(mr1) * SQ_W'(mr1);
    sqi  <= SQ_W'(mi1) * SQ_W'(mi1);
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      fail     <= 1'b0;
      gen_wait <= 1'b0;
    end else begin
      done <= 1'b0;
      if (v2 && (bad2 || ({1'b0, sqr} + {1'b0, sqi}) > {1'b0, tol_sq})) fail <= 1'b1;
      case (state)
        ST_IDLE: begin
          if (start && kind == KIND_COMPARE) begin
            if (n_eff == '0) begin
              done         <= 1'b1;
              matched      <= 1'b1;
              match_form   <= FORM_DIRECT;
              match_origin <= '0;
            end else begin
              n_reg   <= n_eff;
              tol_sq  <= SQ_W'(tolerance) * SQ_W'(tolerance);
              sel     <= SEL_R;
              ret     <= ST_SORTF;
              k       <= '0;
              pcnt    <= '0;
              swapped <= 1'b0;
              state   <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          if (sort_last) begin
            k       <= '0;
            swapped <= 1'b0;
            if (!swapped || pcnt == NW'(MAX_POINTS - 1)) begin
              state <= ret;
            end else begin
              pcnt <= pcnt + 1'b1;
            end
          end else begin
            k       <= k + 1'b1;
            swapped <= swapped | swap;
          end
        end
        ST_SORTF: begin
          sel     <= SEL_F;
          ret     <= ST_CPW;
          k       <= '0;
          pcnt    <= '0;
          swapped <= 1'b0;
          state   <= ST_SORT;
        end
        ST_CPW: begin
          try_form <= FORM_DIRECT;
          state    <= ST_EQI;
        end
        ST_EQI: begin
          i     <= '0;
          j     <= '0;
          fail  <= 1'b0;
          state <= ST_EQ;
        end
        ST_EQ: begin
          if (j == 2'd2) begin
            j <= '0;
            i <= i + 1'b1;
            if (i == n_reg - 1'b1) state <= ST_EQD;
          end else begin
            j <= j + 2'd1;
          end
        end
        ST_EQD: begin
          if (j == 2'd2) begin
            j <= '0;
            if (!fail) begin
              done         <= 1'b1;
              matched      <= 1'b1;
              match_form   <= try_form;
              match_origin <= (try_form == FORM_SHIFT || try_form == FORM_SHIFT_CONJ)
                              ? 3'(o) : 3'd0;
              state        <= ST_IDLE;
            end else begin
              case (try_form)
                FORM_DIRECT: begin
                  try_form <= FORM_CONJ;
                  state    <= ST_CONJ;
                end
                FORM_CONJ: begin
                  o        <= '0;
                  i        <= '0;
                  try_form <= FORM_SHIFT;
                  state    <= ST_PRE;
                end
                FORM_SHIFT: begin
                  try_form <= FORM_SHIFT_CONJ;
                  state    <= ST_CONJ;
                end
                default: begin
                  if (o == n_reg - 1'b1) begin
                    done         <= 1'b1;
                    matched      <= 1'b0;
                    match_form   <= FORM_NONE;
                    match_origin <= '0;
                    state        <= ST_IDLE;
                  end else begin
                    o        <= o + 1'b1;
                    i        <= '0;
                    try_form <= FORM_SHIFT;
                    state    <= ST_PRE;
                  end
                end
              endcase
            end
          end else begin
            j <= j + 2'd1;
          end
        end
        ST_CONJ: begin
          sel     <= SEL_W;
          ret     <= ST_EQI;
          k       <= '0;
          pcnt    <= '0;
          swapped <= 1'b0;
          state   <= ST_SORT;
        end
        ST_PRE: begin
          if (i == o) orig <= r_cells[0];
          if (i == n_reg - 1'b1) begin
            i        <= '0;
            gen_wait <= 1'b0;
            state    <= ST_GEN;
          end else begin
            i <= i + 1'b1;
          end
        end
        ST_GEN: begin
          if (u_start) gen_wait <= 1'b1;
          if (u_done) begin
            gen_wait <= 1'b0;
            if (i == n_reg - 1'b1) begin
              i       <= '0;
              sel     <= SEL_W;
              ret     <= ST_EQI;
              k       <= '0;
              pcnt    <= '0;
              swapped <= 1'b0;
              state   <= ST_SORT;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A result other than a direct match only follows work on a compare.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done && match_form != FORM_DIRECT |-> $past(busy))
    else $error("result without a compare in progress");

  a_matched_form: assert property (@(posedge clk) disable iff (rst)
    done |-> (matched == (match_form != FORM_NONE)))
    else $error("matched flag disagrees with match form");

  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    done && (match_form == FORM_NONE || match_form == FORM_DIRECT ||
             match_form == FORM_CONJ) |-> match_origin == 3'd0)
    else $error("origin reported for an unshifted form");

  a_sort_stays: assert property (@(posedge clk) disable iff (rst)
    state == ST_SORT && !sort_last |=> state == ST_SORT)
    else $error("sort pass left early");

endmodule

FILE: rtl/core/psm_cell.sv
// One cell of a point row: holds one point, loads or conjugates it.
// Depends on psm_pkg.
module psm_cell import psm_pkg::*; (
  input  logic       clk,
  input  logic [1:0] op,
  input  point_t     d,
  output point_t     q
);

  // Point register with in-place conjugation.
  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD: q <= d;
      CELL_CONJ: begin
        for (int k = 0; k < PT_WORDS; k += 2) begin
          q[k]   <= q[k];
          q[k+1] <= neg_sat(q[k+1]);
        end
      end
      default: q <= q;
    endcase
  end

endmodule

FILE: rtl/core/psm_sorter.sv
// Bubble-pass engine: keeps the bubbling point and emits the lesser one.
// Depends on psm_pkg.
module psm_sorter import psm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic             first,
  input  logic             last,
  input  point_t           front,
  input  logic [TOL_W-1:0] tol,
  output point_t           emit,
  output logic             swap
);

  point_t carry;
  logic   after;

  // Compare the carried point with the one leaving the row head.
  always_comb begin
    after = comes_after(carry, front, tol);
    emit  = (last || !after) ? carry : front;
    swap  = en && !first && !last && after;
  end

  // The larger point keeps bubbling toward the tail.
  always_ff @(posedge clk) begin
    if (en) begin
      if (first) begin
        carry <= front;
      end else if (!last && !after) begin
        carry <= front;
      end
    end
  end

endmodule

FILE: rtl/core/psm_row.sv
// Row of point cells: rotates, takes tail pushes, loads, copies or conjugates.
// Depends on psm_pkg and psm_cell.
module psm_row import psm_pkg::*; #(
  parameter int MAX_POINTS = 8,
  parameter int NW = $clog2(MAX_POINTS + 1),
  parameter int IW = $clog2(MAX_POINTS)
) (
  input  logic          clk,
  input  logic [2:0]    op,
  input  logic [NW-1:0] n,
  input  logic [IW-1:0] wr_idx,
  input  point_t        ins,
  input  point_t        cpy [MAX_POINTS],
  output point_t        cells [MAX_POINTS]
);

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic [1:0] cop;
    point_t     cd;
    point_t     nb;

    if (i < MAX_POINTS - 1) begin : g_nb
      assign nb = cells[i+1];
    end else begin : g_end
      assign nb = ins;
    end

    // Per-cell choice: neighbor, tail insert, write, copy or conjugate.
    always_comb begin
      cop = CELL_HOLD;
      cd  = ins;
      case (op)
        ROW_ROT, ROW_PUSH: begin
          if (NW'(i + 1) < n) begin
            cop = CELL_LOAD;
            cd  = nb;
          end else if (NW'(i + 1) == n) begin
            cop = CELL_LOAD;
            cd  = (op == ROW_ROT) ? cells[0] : ins;
          end
        end
        ROW_WRITE: begin
          if (wr_idx == IW'(i)) cop = CELL_LOAD;
        end
        ROW_COPY: begin
          cop = CELL_LOAD;
          cd  = cpy[i];
        end
        ROW_CONJ: cop = CELL_CONJ;
        default: cop = CELL_HOLD;
      endcase
    end

    psm_cell u_cell (
      .clk (clk),
      .op  (cop),
      .d   (cd),
      .q   (cells[i])
    );
  end

endmodule

FILE: rtl/core/psm_shift.sv
// Shift-to-origin unit: multiplies a point by the conjugate of the origin.
// One shared multiplier. Depends on psm_pkg.
module psm_shift import psm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  point_t p,
  input  point_t org,
  input  logic   self,
  output point_t res,
  output logic   done
);

  logic                     run;
  logic [2:0]               sc;
  logic [1:0]               j;
  logic signed [PROD_W-1:0] preg;
  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;
  coord_t                   a, b, cr, ci, ma, mb;
  logic signed [TERM_W-1:0] term;

  // Operand selection for the current partial product.
  always_comb begin
    a    = p[{j, 1'b0}];
    b    = p[{j, 1'b1}];
    cr   = org[{j, 1'b0}];
    ci   = org[{j, 1'b1}];
    term = $signed(preg[PROD_W-1:FRAC]);
    case (sc)
      3'd1:    begin ma = b; mb = ci; end
      3'd2:    begin ma = b; mb = cr; end
      3'd3:    begin ma = a; mb = ci; end
      default: begin ma = a; mb = cr; end
    endcase
  end

  // Sequencer over coordinates and product steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      sc   <= '0;
      j    <= '0;
    end else begin
      done <= 1'b0;
      if (start && !run) begin
        run <= 1'b1;
        sc  <= '0;
        j   <= '0;
      end else if (run) begin
        if (sc == 3'd5) begin
          sc <= '0;
          if (j == 2'd2) begin
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            j <= j + 2'd1;
          end
        end else begin
          sc <= sc + 3'd1;
        end
      end
    end
  end

  // Floored partial products are accumulated one per cycle.
  always_ff @(posedge clk) begin
    preg <= PROD_W'(ma) * PROD_W'(mb);
    case (sc)
      3'd1: acc_re <= ACC_W'(term);
      3'd2: acc_re <= acc_re + ACC_W'(term);
      3'd3: acc_im <= ACC_W'(term);
      3'd4: acc_im <= acc_im - ACC_W'(term);
      3'd5: begin
        if (run) begin
          res[{j, 1'b0}] <= self ? cr : sat_acc(acc_re);
          res[{j, 1'b1}] <= self ? neg_sat(ci) : sat_acc(acc_im);
        end
      end
      default: acc_re <= acc_re;
    endcase
  end

endmodule
